@@ src/spq_pkg.sv @@
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int OP_W          = 2;
    localparam int COUNT_OUT_W   = 5;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 40;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic compare;
        logic apply;
        logic load_out;
    } spq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_remove;
        logic any_eq;
        logic out_free;
    } spq_status_t;

endpackage

@@ src/spq_ctrl.sv @@
module spq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  spq_pkg::spq_status_t status,
    output spq_pkg::spq_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd.load_item = 1'b0;
        cmd.compare   = 1'b0;
        cmd.apply     = 1'b0;
        cmd.load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                // a remove deletes one match per pass, then looks again
                if (status.is_remove && status.any_eq) begin
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/spq_datapath.sv @@
module spq_datapath #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [spq_pkg::OP_W-1:0]             in_op,
    input  logic signed [spq_pkg::VALUE_W-1:0]   in_value,
    input  spq_pkg::spq_cmd_t                    cmd,
    output spq_pkg::spq_status_t                 status,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic signed [spq_pkg::VALUE_W-1:0]   out_front_value,
    output logic                                 out_front_valid,
    output logic [spq_pkg::COUNT_OUT_W-1:0]      out_entry_count,
    output logic                                 out_push_dropped
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [spq_pkg::OP_W-1:0]           op_reg;
    logic signed [spq_pkg::VALUE_W-1:0] val_reg;
    logic signed [spq_pkg::VALUE_W-1:0] cell_reg  [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0] cell_next [DEPTH];
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [DEPTH-1:0]                   ge_reg;
    logic [DEPTH-1:0]                   ge_next;
    logic [DEPTH-1:0]                   eq_reg;
    logic [DEPTH-1:0]                   eq_next;
    logic                               drop_reg;
    logic                               m_tvalid_reg;
    logic signed [spq_pkg::VALUE_W-1:0] front_reg;
    logic                               fvalid_reg;
    logic [spq_pkg::COUNT_OUT_W-1:0]    ecount_reg;
    logic                               pdrop_reg;

    logic full;
    logic empty;
    logic any_eq;
    logic is_push;
    logic is_pop;
    logic is_remove;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign any_eq    = |eq_reg;
    assign is_push   = (op_reg == spq_pkg::OP_PUSH);
    assign is_pop    = (op_reg == spq_pkg::OP_POP);
    assign is_remove = (op_reg == spq_pkg::OP_REMOVE);

    assign status.is_remove = is_remove;
    assign status.any_eq    = any_eq;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // per-cell compare; empty cells count as "greater or equal"
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic valid;
            assign valid       = (CW'(gi) < count_reg);
            assign ge_next[gi] = !valid || (cell_reg[gi] >= val_reg);
            assign eq_next[gi] = valid && (cell_reg[gi] == val_reg);

            logic shl_src;  // take from the right neighbor
            logic shr_src;  // take from the left neighbor
            logic ins;      // insertion point

            if (gi < DEPTH - 1) begin : g_right
                assign shl_src = (is_pop && !empty) || (is_remove && any_eq && ge_reg[gi]);
            end else begin : g_last
                assign shl_src = 1'b0;
            end

            if (gi == 0) begin : g_first
                assign shr_src = 1'b0;
                assign ins     = is_push && !full && ge_reg[gi];
            end else begin : g_rest
                assign shr_src = is_push && !full && ge_reg[gi-1];
                assign ins     = is_push && !full && ge_reg[gi] && !ge_reg[gi-1];
            end

            always_comb begin
                cell_next[gi] = cell_reg[gi];
                if (ins) begin
                    cell_next[gi] = val_reg;
                end else if (shr_src) begin
                    cell_next[gi] = cell_reg[(gi > 0) ? gi - 1 : 0];
                end else if (shl_src) begin
                    cell_next[gi] = cell_reg[(gi < DEPTH - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge aclk) begin
                if (cmd.apply) begin
                    cell_reg[gi] <= cell_next[gi];
                end
            end
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (is_push && !full) begin
            count_next = count_reg + CW'(1);
        end else if (is_pop && !empty) begin
            count_next = count_reg - CW'(1);
        end else if (is_remove && any_eq) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.apply) begin
                count_reg <= count_next;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= in_op;
            val_reg  <= in_value;
            drop_reg <= 1'b0;
        end
        if (cmd.compare) begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
        if (cmd.apply && is_push && full) begin
            drop_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            front_reg  <= empty ? '0 : cell_reg[0];
            fvalid_reg <= !empty;
            ecount_reg <= spq_pkg::COUNT_OUT_W'(count_reg);
            pdrop_reg  <= drop_reg;
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign out_front_value  = front_reg;
    assign out_front_valid  = fvalid_reg;
    assign out_entry_count  = ecount_reg;
    assign out_push_dropped = pdrop_reg;

endmodule

@@ src/sorted_priority_queue.sv @@
// Channel  Dir  Beat contents                                   Handshake
// s_       in   tuser: operation[1:0]; tdata: value[31:0]      s_tvalid / s_tready
// m_       out  tdata: front_value, front_valid, entry_count,  m_tvalid / m_tready
//               push_dropped (one result beat per input beat)
//
// Push and pop run four steps from accept to the next accept: register the beat,
// the row-wide compare, the shift, and loading the output once m_ is free.
// A remove repeats the compare/shift pass over the entry row until no match is
// left; each pass deletes one match.
// aresetn (synchronous, active low) empties the store; entry contents are not cleared.
// A new beat is taken while a result waits on m_; only loading the next result
// waits for m_tready.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // value[31:0]
    input  logic [spq_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation[1:0]
    input  logic [spq_pkg::OP_W-1:0]         s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // front_value[31:0], front_valid[32], entry_count[37:33], push_dropped[38], zero[39]
    output logic [spq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    spq_pkg::spq_cmd_t    cmd;
    spq_pkg::spq_status_t status;

    logic signed [spq_pkg::VALUE_W-1:0]  front_value;
    logic                                front_valid;
    logic [spq_pkg::COUNT_OUT_W-1:0]     entry_count;
    logic                                push_dropped;

    // sequencing: register beat, compare, shift (repeat for remove), publish
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // entry row, count and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_op            (s_tuser),
        .in_value         (s_tdata[spq_pkg::VALUE_W-1:0]),
        .cmd              (cmd),
        .status           (status),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_front_value  (front_value),
        .out_front_valid  (front_valid),
        .out_entry_count  (entry_count),
        .out_push_dropped (push_dropped)
    );

    // pack result fields from the low bit up, pad to whole bytes
    assign m_tdata = {1'b0, push_dropped, entry_count, front_valid, front_value};

endmodule

@@ tb/spq_checker.sv @@
// Watches both channels of sorted_priority_queue, keeps a shadow copy of the
// ordered store and checks every result beat against the front it predicts.
module spq_checker #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [spq_pkg::OP_W-1:0]      s_tuser,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    output int                            fail_count,
    output int                            items_taken,
    output int                            results_checked,
    output int                            pending,
    output int                            refused_pushes,
    output int                            removes_hit,
    output int                            peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] front_value;
        logic               front_valid;
        logic [4:0]         entry_count;
        logic               push_dropped;
    } front_report_t;

    logic signed [31:0] shadow_store [DEPTH];
    int                 shadow_fill;
    front_report_t      expected_fronts [$];

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d mismatch on %s: got %h, want %h",
                 $realtime, results_checked, field, got, want);
        fail_count++;
    endtask

    // Applies one operation to the shadow store and returns the front it leaves.
    function automatic front_report_t predict_front(input logic [spq_pkg::OP_W-1:0] op,
                                                    input logic signed [31:0] val);
        front_report_t r;
        int pos;
        int wr;
        int i;
        r.push_dropped = 1'b0;
        case (op)
            spq_pkg::OP_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    r.push_dropped = 1'b1;
                    refused_pushes++;
                end else begin
                    // lands before the first entry >= val
                    pos = 0;
                    while (pos < shadow_fill && shadow_store[pos] < val)
                        pos++;
                    for (i = shadow_fill; i > pos; i--)
                        shadow_store[i] = shadow_store[i-1];
                    shadow_store[pos] = val;
                    shadow_fill++;
                end
            end
            spq_pkg::OP_POP: begin
                if (shadow_fill > 0) begin
                    for (i = 1; i < shadow_fill; i++)
                        shadow_store[i-1] = shadow_store[i];
                    shadow_fill--;
                end
            end
            spq_pkg::OP_REMOVE: begin
                wr = 0;
                for (i = 0; i < shadow_fill; i++) begin
                    if (shadow_store[i] != val) begin
                        shadow_store[wr] = shadow_store[i];
                        wr++;
                    end
                end
                if (wr < shadow_fill)
                    removes_hit++;
                shadow_fill = wr;
            end
            default: ;  // unused code: store untouched
        endcase
        if (shadow_fill > peak_fill)
            peak_fill = shadow_fill;
        r.front_valid = (shadow_fill > 0);
        r.front_value = (shadow_fill > 0) ? shadow_store[0] : 32'sd0;
        r.entry_count = 5'(shadow_fill);
        return r;
    endfunction

    always @(posedge aclk) begin
        front_report_t want;
        if (!aresetn) begin
            shadow_fill     = 0;
            expected_fronts.delete();
            fail_count      = 0;
            items_taken     = 0;
            results_checked = 0;
            pending         = 0;
            refused_pushes  = 0;
            removes_hit     = 0;
            peak_fill       = 0;
        end else begin
            // result side first: a beat leaving now belongs to an earlier input
            if (m_tvalid && m_tready) begin
                if (expected_fronts.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_fronts.pop_front();
                    if (m_tdata[31:0] !== want.front_value)
                        report_mismatch("front_value", m_tdata[31:0], want.front_value);
                    if (m_tdata[32] !== want.front_valid)
                        report_mismatch("front_valid", 32'(m_tdata[32]), 32'(want.front_valid));
                    if (m_tdata[37:33] !== want.entry_count)
                        report_mismatch("entry_count", 32'(m_tdata[37:33]),
                                        32'(want.entry_count));
                    if (m_tdata[38] !== want.push_dropped)
                        report_mismatch("push_dropped", 32'(m_tdata[38]),
                                        32'(want.push_dropped));
                    if (m_tdata[39] !== 1'b0)
                        report_mismatch("pad bit", 32'(m_tdata[39]), 32'd0);
                end
                results_checked++;
            end
            if (s_tvalid && s_tready) begin
                expected_fronts.push_back(predict_front(s_tuser, s_tdata));
                items_taken++;
            end
            pending = expected_fronts.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
// Stimulus and verdict for sorted_priority_queue. Checking lives in spq_checker;
// this module only drives beats, paces both channels and reports the outcome.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = spq_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1950;
    // worst case per item: a remove of DEPTH matches plus sender gap and receiver
    // stall; the limit is set well above the total for all items
    localparam int CYCLE_LIMIT  = 600000;
    // settle time after the last result, beyond the longest remove
    localparam int TAIL_CYCLES  = 4 + 2 * DEPTH + 40;
    localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int HOLD_AT      = 900;   // beats taken before the hold-off starts

    // the one code the block does not use: a no-op that still returns a result
    localparam logic [spq_pkg::OP_W-1:0] OP_NOP = 2'd3;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

    typedef enum int { EP_FILL, EP_DRAIN, EP_MIXED } episode_t;
    typedef enum int { RX_OPEN, RX_PATTERN, RX_RANDOM } rx_mode_t;

    logic                          aclk;
    logic                          aresetn;
    logic [spq_pkg::S_TDATA_W-1:0] s_tdata;
    logic [spq_pkg::OP_W-1:0]      s_tuser;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tvalid;
    logic                          m_tready;

    int fail_count;
    int items_taken;
    int results_checked;
    int pending;
    int refused_pushes;
    int removes_hit;
    int peak_fill;

    int items_sent;
    int burst_left;
    int cycles;

    sorted_priority_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    spq_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .fail_count     (fail_count),
        .items_taken    (items_taken),
        .results_checked(results_checked),
        .pending        (pending),
        .refused_pushes (refused_pushes),
        .removes_hit    (removes_hit),
        .peak_fill      (peak_fill)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycles, pending);
        $display("testbench failed");
        $finish;
    end

    // Presents one beat at the current falling edge and holds it until taken.
    // Returns on the falling edge after the accept, tvalid still high.
    task automatic send_beat(input logic [spq_pkg::OP_W-1:0] op, input logic [31:0] val);
        s_tuser  = op;
        s_tdata  = val;
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Sender pacing: bursts of random length, then a gap (sometimes none).
    task automatic send_item(input logic [spq_pkg::OP_W-1:0] op, input logic [31:0] val);
        int gap;
        send_beat(op, val);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
    endtask

    // Sender goes quiet until every predicted result has come back.
    task automatic wait_for_drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    // Mostly a tight pool so pushes collide and removes find matches.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 32'($urandom_range(0, 6)) - 32'd3;
        if (r < 62) begin
            case ($urandom_range(0, 3))
                0:       return INT_MIN;
                1:       return INT_MAX;
                2:       return INT_MIN + 32'd1;
                default: return INT_MAX - 32'd1;
            endcase
        end
        return $urandom;
    endfunction

    // Receiver: open, rotating-mask or random stall stretches, plus one long
    // hold-off partway through so the block backs up into s_tready.
    initial begin
        rx_mode_t    mode;
        int          stretch;
        int          hold;
        logic [15:0] mask;
        bit          long_hold_done;
        m_tready       = 1'b0;
        mode           = RX_OPEN;
        stretch        = 0;
        hold           = 0;
        mask           = '1;
        long_hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && items_taken >= HOLD_AT) begin
                long_hold_done = 1'b1;
                hold           = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = rx_mode_t'($urandom_range(0, 2));
                    stretch = $urandom_range(32, 200);
                    mask    = 16'($urandom) | 16'h0001;
                end
                stretch--;
                case (mode)
                    RX_OPEN: m_tready = 1'b1;
                    RX_PATTERN: begin
                        m_tready = mask[0];
                        mask     = {mask[0], mask[15:1]};
                    end
                    default: m_tready = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        episode_t                 kind;
        int                       len;
        int                       n;
        int                       r;
        int                       episodes;
        logic [spq_pkg::OP_W-1:0] op;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = spq_pkg::OP_PUSH;
        items_sent = 0;
        burst_left = 1;
        episodes   = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes of the value range, duplicates, remove with two
        // matches and with none, the unused code, and pop/remove on empty.
        send_item(spq_pkg::OP_PUSH,   INT_MIN);
        send_item(spq_pkg::OP_PUSH,   INT_MAX);
        send_item(spq_pkg::OP_PUSH,   32'd0);
        send_item(spq_pkg::OP_PUSH,   32'd0);
        send_item(spq_pkg::OP_PUSH,   32'hffff_ffff);
        send_item(spq_pkg::OP_PUSH,   32'd1);
        send_item(spq_pkg::OP_REMOVE, 32'd0);
        send_item(spq_pkg::OP_REMOVE, 32'd12345);
        send_item(OP_NOP,             32'hffff_ffff);
        send_item(spq_pkg::OP_POP,    32'hdead_beef);
        send_item(spq_pkg::OP_POP,    32'd0);
        send_item(spq_pkg::OP_POP,    32'd0);
        send_item(spq_pkg::OP_POP,    32'd0);
        send_item(spq_pkg::OP_POP,    32'd0);
        send_item(spq_pkg::OP_REMOVE, INT_MIN);
        send_item(OP_NOP,             32'd0);
        send_item(spq_pkg::OP_PUSH,   INT_MAX);
        send_item(spq_pkg::OP_PUSH,   INT_MAX);
        send_item(spq_pkg::OP_REMOVE, INT_MAX);
        wait_for_drain();

        // Random: episodes that fill to overflow, drain to empty, or churn.
        while (items_sent < RANDOM_ITEMS + 19) begin
            kind = episode_t'($urandom_range(0, 2));
            len  = $urandom_range(8, 40);
            for (n = 0; n < len; n++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    EP_FILL:
                        op = (r < 85) ? spq_pkg::OP_PUSH :
                             (r < 93) ? spq_pkg::OP_POP :
                             (r < 98) ? spq_pkg::OP_REMOVE : OP_NOP;
                    EP_DRAIN:
                        op = (r < 75) ? spq_pkg::OP_POP :
                             (r < 85) ? spq_pkg::OP_PUSH :
                             (r < 97) ? spq_pkg::OP_REMOVE : OP_NOP;
                    default:
                        op = (r < 45) ? spq_pkg::OP_PUSH :
                             (r < 70) ? spq_pkg::OP_POP :
                             (r < 95) ? spq_pkg::OP_REMOVE : OP_NOP;
                endcase
                send_item(op, pick_value());
            end
            episodes++;
            if (episodes % 10 == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("%0d beats in, %0d results checked over %0d episodes", items_taken,
                 results_checked, episodes);
        $display("%0d pushes refused when full, %0d removes with matches, peak fill %0d/%0d",
                 refused_pushes, removes_hit, peak_fill, DEPTH);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
